// File: hw/rtl/cda_pkg.sv
package cda_pkg;

    localparam int ReqW   = 2;
    localparam int AmtW   = 15;
    localparam int DayW   = 5;
    localparam int MonW   = 4;
    localparam int YearW  = 15;
    localparam int FlagW  = 2;
    localparam int SDataW = 40;
    localparam int MDataW = 24;
    localparam int PcW    = 4;

    localparam logic [YearW-1:0] YEAR_MAX  = YearW'(32767);
    localparam logic [MonW-1:0]  MON_JAN   = MonW'(1);
    localparam logic [MonW-1:0]  MON_FEB   = MonW'(2);
    localparam logic [MonW-1:0]  MON_DEC   = MonW'(12);
    localparam logic [DayW-1:0]  DAY_FIRST = DayW'(1);

    // year split into century count and year within century
    localparam int QuoW = 9;
    localparam int CenW = 7;
    localparam int RecipW = 13;
    localparam logic [RecipW-1:0] RECIP_100 = RecipW'(5243);
    localparam int RecipShift = 19;
    localparam logic [CenW-1:0] CEN_LAST = CenW'(99);
    localparam logic [CenW-1:0] CEN_HUNDRED = CenW'(100);

    localparam logic [ReqW-1:0] REQ_DAYS   = 2'd0;
    localparam logic [ReqW-1:0] REQ_MONTHS = 2'd1;
    localparam logic [ReqW-1:0] REQ_YEARS  = 2'd2;

    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_LOAD,
        ACT_DIV,
        ACT_REM,
        ACT_CHECK,
        ACT_DAY,
        ACT_MONTH,
        ACT_YEAR,
        ACT_EMIT
    } act_t;

    typedef enum logic [3:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_INVALID,
        COND_REQ_DAY,
        COND_REQ_MONTH,
        COND_REQ_YEAR,
        COND_CNT_NZ,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        act_t           act;
        cond_t          cond;
        logic [PcW-1:0] target;
    } uword_t;

    typedef struct packed {
        act_t act;
    } ctrl_t;

    typedef struct packed {
        logic no_input;
        logic invalid;
        logic req_day;
        logic req_month;
        logic req_year;
        logic cnt_nz;
        logic out_busy;
    } status_t;

    function automatic logic [DayW-1:0] month_days(input logic [MonW-1:0] mon,
                                                   input logic leap);
        logic [DayW-1:0] len;
        unique case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayW'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DayW'(30);
            4'd2:                                       len = leap ? DayW'(29) : DayW'(28);
            default:                                    len = '0;
        endcase
        return len;
    endfunction

endpackage

// File: hw/rtl/cda_useq.sv
module cda_useq (
    input  logic             aclk,
    input  logic             aresetn,
    input  cda_pkg::status_t status,
    output cda_pkg::ctrl_t   ctrl
);
    import cda_pkg::*;

    localparam logic [PcW-1:0] ADDR_FETCH = 4'd0;
    localparam logic [PcW-1:0] ADDR_DLOOP = 4'd8;
    localparam logic [PcW-1:0] ADDR_MLOOP = 4'd10;
    localparam logic [PcW-1:0] ADDR_YEARS = 4'd12;
    localparam logic [PcW-1:0] ADDR_EMIT  = 4'd13;

    function automatic uword_t rom(input logic [PcW-1:0] addr);
        uword_t w;
        unique case (addr)
            4'd0:    w = '{ACT_LOAD,  COND_NO_INPUT,  ADDR_FETCH};
            4'd1:    w = '{ACT_DIV,   COND_NONE,      ADDR_FETCH};
            4'd2:    w = '{ACT_REM,   COND_NONE,      ADDR_FETCH};
            4'd3:    w = '{ACT_CHECK, COND_INVALID,   ADDR_EMIT};
            4'd4:    w = '{ACT_NOP,   COND_REQ_YEAR,  ADDR_YEARS};
            4'd5:    w = '{ACT_NOP,   COND_REQ_MONTH, ADDR_MLOOP};
            4'd6:    w = '{ACT_NOP,   COND_REQ_DAY,   ADDR_DLOOP};
            4'd7:    w = '{ACT_NOP,   COND_ALWAYS,    ADDR_EMIT};
            4'd8:    w = '{ACT_DAY,   COND_CNT_NZ,    ADDR_DLOOP};
            4'd9:    w = '{ACT_NOP,   COND_ALWAYS,    ADDR_EMIT};
            4'd10:   w = '{ACT_MONTH, COND_CNT_NZ,    ADDR_MLOOP};
            4'd11:   w = '{ACT_NOP,   COND_ALWAYS,    ADDR_EMIT};
            4'd12:   w = '{ACT_YEAR,  COND_NONE,      ADDR_FETCH};
            4'd13:   w = '{ACT_EMIT,  COND_OUT_BUSY,  ADDR_EMIT};
            default: w = '{ACT_NOP,   COND_ALWAYS,    ADDR_FETCH};
        endcase
        return w;
    endfunction

    logic [PcW-1:0] pc_reg, pc_next;
    uword_t         uw;
    logic           take;

    assign uw       = rom(pc_reg);
    assign ctrl.act = uw.act;

    always_comb begin
        unique case (uw.cond)
            COND_NONE:      take = 1'b0;
            COND_ALWAYS:    take = 1'b1;
            COND_NO_INPUT:  take = status.no_input;
            COND_INVALID:   take = status.invalid;
            COND_REQ_DAY:   take = status.req_day;
            COND_REQ_MONTH: take = status.req_month;
            COND_REQ_YEAR:  take = status.req_year;
            COND_CNT_NZ:    take = status.cnt_nz;
            COND_OUT_BUSY:  take = status.out_busy;
            default:        take = 1'b0;
        endcase
        pc_next = take ? uw.target : pc_reg + PcW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ADDR_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: hw/rtl/cda_dpath.sv
module cda_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cda_pkg::ctrl_t              ctrl,
    output cda_pkg::status_t            status,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [cda_pkg::SDataW-1:0]  s_tdata,
    input  logic [cda_pkg::ReqW-1:0]    s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cda_pkg::MDataW-1:0]  m_tdata,
    output logic [cda_pkg::FlagW-1:0]   m_tuser
);
    import cda_pkg::*;

    logic [ReqW-1:0]   req_reg;
    logic [AmtW-1:0]   cnt_reg;
    logic [DayW-1:0]   day_reg;
    logic [MonW-1:0]   mon_reg;
    logic [YearW-1:0]  year_reg;
    logic [QuoW-1:0]   quo_reg;
    logic [CenW-1:0]   cen_reg;
    logic              bad_reg;
    logic              ovf_reg;
    logic              out_valid_reg;
    logic [DayW-1:0]   out_day_reg;
    logic [MonW-1:0]   out_mon_reg;
    logic [YearW-1:0]  out_year_reg;
    logic              out_bad_reg;
    logic              out_ovf_reg;

    logic                      leap;
    logic [DayW-1:0]           cur_len;
    logic [DayW-1:0]           next_len;
    logic [MonW-1:0]           mon_inc;
    logic [YearW+RecipW-1:0]   recip_prod;
    logic [YearW-1:0]          cen_prod;
    logic [YearW:0]            year_sum;
    logic                      out_busy;
    logic                      load;
    logic                      emit;

    assign leap     = (cen_reg == '0) ? (quo_reg[1:0] == 2'd0) : (cen_reg[1:0] == 2'd0);
    assign cur_len  = month_days(mon_reg, leap);
    assign mon_inc  = mon_reg + MonW'(1);
    assign next_len = month_days(mon_inc, leap);

    assign recip_prod = YearW'(year_reg) * RECIP_100;
    assign cen_prod   = YearW'(quo_reg) * YearW'(CEN_HUNDRED);
    assign year_sum   = {1'b0, year_reg} + {1'b0, cnt_reg};

    assign out_busy = out_valid_reg && !m_tready;
    assign s_tready = (ctrl.act == ACT_LOAD);
    assign load     = s_tready && s_tvalid;
    assign emit     = (ctrl.act == ACT_EMIT) && !out_busy;

    assign status.no_input  = !s_tvalid;
    assign status.invalid   = (mon_reg < MON_JAN) || (mon_reg > MON_DEC) ||
                              (day_reg == '0) || (day_reg > cur_len);
    assign status.req_day   = (req_reg == REQ_DAYS);
    assign status.req_month = (req_reg == REQ_MONTHS);
    assign status.req_year  = (req_reg == REQ_YEARS);
    assign status.cnt_nz    = (cnt_reg != '0);
    assign status.out_busy  = out_busy;

    // working registers
    always_ff @(posedge aclk) begin
        unique case (ctrl.act)
            ACT_LOAD: begin
                if (load) begin
                    req_reg  <= s_tuser;
                    cnt_reg  <= s_tdata[AmtW-1:0];
                    day_reg  <= s_tdata[AmtW +: DayW];
                    mon_reg  <= s_tdata[AmtW+DayW +: MonW];
                    year_reg <= s_tdata[AmtW+DayW+MonW +: YearW];
                    bad_reg  <= 1'b0;
                    ovf_reg  <= 1'b0;
                end
            end
            ACT_DIV: begin
                quo_reg <= recip_prod[RecipShift +: QuoW];
            end
            ACT_REM: begin
                cen_reg <= CenW'(year_reg - cen_prod);
            end
            ACT_CHECK: begin
                bad_reg <= status.invalid;
            end
            ACT_DAY: begin
                if (cnt_reg != '0) begin
                    if (day_reg == cur_len) begin
                        if (mon_reg == MON_DEC) begin
                            if (year_reg == YEAR_MAX) begin
                                ovf_reg <= 1'b1;
                                cnt_reg <= '0;
                            end else begin
                                day_reg  <= DAY_FIRST;
                                mon_reg  <= MON_JAN;
                                year_reg <= year_reg + YearW'(1);
                                cen_reg  <= (cen_reg == CEN_LAST) ? '0 : cen_reg + CenW'(1);
                                quo_reg  <= (cen_reg == CEN_LAST) ? quo_reg + QuoW'(1) : quo_reg;
                                cnt_reg  <= cnt_reg - AmtW'(1);
                            end
                        end else begin
                            day_reg <= DAY_FIRST;
                            mon_reg <= mon_inc;
                            cnt_reg <= cnt_reg - AmtW'(1);
                        end
                    end else begin
                        day_reg <= day_reg + DayW'(1);
                        cnt_reg <= cnt_reg - AmtW'(1);
                    end
                end
            end
            ACT_MONTH: begin
                if (cnt_reg != '0) begin
                    if (mon_reg == MON_DEC) begin
                        if (year_reg == YEAR_MAX) begin
                            ovf_reg <= 1'b1;
                            cnt_reg <= '0;
                        end else begin
                            // january is 31 days long, no clamp needed
                            mon_reg  <= MON_JAN;
                            year_reg <= year_reg + YearW'(1);
                            cen_reg  <= (cen_reg == CEN_LAST) ? '0 : cen_reg + CenW'(1);
                            quo_reg  <= (cen_reg == CEN_LAST) ? quo_reg + QuoW'(1) : quo_reg;
                            cnt_reg  <= cnt_reg - AmtW'(1);
                        end
                    end else begin
                        mon_reg <= mon_inc;
                        if (day_reg > next_len) begin
                            day_reg <= next_len;
                        end
                        cnt_reg <= cnt_reg - AmtW'(1);
                    end
                end
            end
            ACT_YEAR: begin
                if (year_sum[YearW]) begin
                    year_reg <= YEAR_MAX;
                    ovf_reg  <= 1'b1;
                end else begin
                    year_reg <= year_sum[YearW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_day_reg  <= day_reg;
            out_mon_reg  <= mon_reg;
            out_year_reg <= year_reg;
            out_bad_reg  <= bad_reg;
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_year_reg, out_mon_reg, out_day_reg};
    assign m_tuser  = {out_ovf_reg, out_bad_reg};

endmodule

// File: hw/rtl/calendar_date_advance.sv
// channel   dir  tdata (low bit up)                        tuser
// s_        in   amount, day_in, month_in, year_in, zeros  req_type
// m_        out  day_out, month_out, year_out              bad_date, year_overflow
//
// days and months requests walk the amount, years requests add it at once;
// unused codes and invalid dates go to emit; a step loop moves one unit per cycle
// one transaction is in work at a time, s_tready is high only while the
// sequencer waits at its fetch step
// a waiting result stalls the sequencer at its emit step until m_tready
// aresetn is synchronous and active low, it returns the sequencer to fetch
module calendar_date_advance (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // amount, day_in, month_in, year_in, zero fill
    input  logic [cda_pkg::SDataW-1:0]  s_tdata,
    // req_type
    input  logic [cda_pkg::ReqW-1:0]    s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // day_out, month_out, year_out
    output logic [cda_pkg::MDataW-1:0]  m_tdata,
    // bad_date, year_overflow
    output logic [cda_pkg::FlagW-1:0]   m_tuser
);
    import cda_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    cda_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    cda_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hw/rtl/cda_checker.sv
module cda_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [cda_pkg::SDataW-1:0]  s_tdata,
    input logic [cda_pkg::ReqW-1:0]    s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [cda_pkg::MDataW-1:0]  m_tdata,
    input logic [cda_pkg::FlagW-1:0]   m_tuser
);
    import cda_pkg::*;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new transaction taken while one is in work");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("bad date and overflow both set");

    a_ovf_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[MDataW-1 -: YearW] == YEAR_MAX)
        else $error("overflow without saturated year");

endmodule

bind calendar_date_advance cda_checker u_cda_checker (.*);

// File: test/tb_calendar_date_advance.sv
`timescale 1ns / 1ps

module tb_calendar_date_advance;

    import cda_pkg::*;

    localparam logic [ReqW-1:0] REQ_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PER_PHASE = 25;

    typedef struct packed {
        logic [DayW-1:0]  day;
        logic [MonW-1:0]  mon;
        logic [YearW-1:0] year;
        logic             bad;
        logic             ovf;
    } date_t;

    typedef struct packed {
        logic [ReqW-1:0]  req;
        logic [AmtW-1:0]  amt;
        logic [DayW-1:0]  day;
        logic [MonW-1:0]  mon;
        logic [YearW-1:0] year;
        logic             typed;
        date_t            want;
    } stim_row_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SDataW-1:0] s_tdata = '0;
    logic [ReqW-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MDataW-1:0] m_tdata;
    logic [FlagW-1:0] m_tuser;

    date_t expected_dates[$];
    stim_row_t dir_rows[$];
    int phase = 0;
    int errors = 0;
    int results_seen = 0;
    int n_directed = 0;
    int n_random = 0;
    int n_bad = 0;
    int n_ovf = 0;
    int idle_count = 0;
    bit hold_done = 1'b0;

    calendar_date_advance dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic bit is_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_of(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            4, 6, 9, 11: len = 30;
            2:           len = is_leap(y) ? 29 : 28;
            1, 3, 5, 7, 8, 10, 12: len = 31;
            default:     len = 0;
        endcase
        return len;
    endfunction

    function automatic date_t advance_date(input logic [ReqW-1:0] req,
                                           input logic [AmtW-1:0] amt,
                                           input logic [DayW-1:0] d_in,
                                           input logic [MonW-1:0] m_in,
                                           input logic [YearW-1:0] y_in);
        date_t r;
        int unsigned d, m, y, n, len;
        logic bad, ovf;
        d = d_in;
        m = m_in;
        y = y_in;
        bad = 1'b0;
        ovf = 1'b0;
        if (m < 1 || m > 12 || d == 0 || d > days_of(y, m)) begin
            bad = 1'b1;
        end else if (req == REQ_DAYS) begin
            for (n = 0; n < amt; n++) begin
                if (d == days_of(y, m)) begin
                    if (m == MON_DEC) begin
                        if (y >= YEAR_MAX) begin
                            ovf = 1'b1;
                            break;
                        end
                        d = DAY_FIRST;
                        m = MON_JAN;
                        y++;
                    end else begin
                        d = DAY_FIRST;
                        m++;
                    end
                end else begin
                    d++;
                end
            end
        end else if (req == REQ_MONTHS) begin
            for (n = 0; n < amt; n++) begin
                if (m == MON_DEC) begin
                    if (y >= YEAR_MAX) begin
                        ovf = 1'b1;
                        break;
                    end
                    m = MON_JAN;
                    y++;
                end else begin
                    m++;
                end
                len = days_of(y, m);
                if (d > len) d = len;
            end
        end else if (req == REQ_YEARS) begin
            y = y + amt;
            if (y > YEAR_MAX) begin
                y = YEAR_MAX;
                ovf = 1'b1;
            end
        end
        r.day = d[DayW-1:0];
        r.mon = m[MonW-1:0];
        r.year = y[YearW-1:0];
        r.bad = bad;
        r.ovf = ovf;
        return r;
    endfunction

    function automatic date_t mk_date(input int unsigned d, input int unsigned m,
                                      input int unsigned y, input bit bad, input bit ovf);
        date_t r;
        r.day = d[DayW-1:0];
        r.mon = m[MonW-1:0];
        r.year = y[YearW-1:0];
        r.bad = bad;
        r.ovf = ovf;
        return r;
    endfunction

    function automatic string date_str(input date_t r);
        return $sformatf("d=%0d m=%0d y=%0d bad=%0b ovf=%0b",
                         r.day, r.mon, r.year, r.bad, r.ovf);
    endfunction

    function automatic int idle_pct(input bit receiver);
        int pct;
        case (phase)
            1:       pct = receiver ? 85 : 27;
            2:       pct = receiver ? 27 : 85;
            default: pct = 0;
        endcase
        return pct;
    endfunction

    task automatic add_row(input logic [ReqW-1:0] req, input int unsigned amt,
                           input int unsigned d, input int unsigned m, input int unsigned y,
                           input bit typed, input date_t want);
        stim_row_t row;
        row.req = req;
        row.amt = amt[AmtW-1:0];
        row.day = d[DayW-1:0];
        row.mon = m[MonW-1:0];
        row.year = y[YearW-1:0];
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic offer(input stim_row_t row);
        date_t want;
        want = row.typed ? row.want : advance_date(row.req, row.amt, row.day, row.mon, row.year);
        while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, row.year, row.mon, row.day, row.amt};
        s_tuser <= row.req;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_dates.push_back(want);
        if (want.bad) n_bad++;
        if (want.ovf) n_ovf++;
        @(negedge aclk);
    endtask

    task automatic make_random(output stim_row_t row);
        int unsigned y, m, d, len, sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) y = $urandom_range(32600, 32767);
        else if (sel < 4) y = $urandom_range(0, 327) * 100;
        else if (sel < 5) y = $urandom_range(0, 8);
        else y = $urandom_range(0, 32767);
        m = $urandom_range(1, 12);
        len = days_of(y, m);
        d = ($urandom_range(0, 9) < 3) ? len : $urandom_range(1, len);
        row.req = ReqW'($urandom_range(0, 2));
        sel = $urandom_range(0, 99);
        if (sel < 80) row.amt = AmtW'($urandom_range(0, 60));
        else if (sel < 95) row.amt = AmtW'($urandom_range(0, 1500));
        else row.amt = AmtW'($urandom_range(0, 32767));
        if ($urandom_range(0, 99) < 25) begin
            // malformed or unused-code transaction
            row.req = ReqW'($urandom_range(0, 3));
            row.amt = AmtW'($urandom_range(0, 300));
            d = $urandom_range(0, 31);
            m = $urandom_range(0, 15);
            y = $urandom_range(0, 32767);
        end
        row.day = d[DayW-1:0];
        row.mon = m[MonW-1:0];
        row.year = y[YearW-1:0];
        row.typed = 1'b0;
        row.want = '0;
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            if (phase == 3 && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
            end
        end
    end

    always @(posedge aclk) begin
        date_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.day = m_tdata[DayW-1:0];
            got.mon = m_tdata[DayW+MonW-1:DayW];
            got.year = m_tdata[DayW+MonW+YearW-1:DayW+MonW];
            got.bad = m_tuser[0];
            got.ovf = m_tuser[1];
            results_seen++;
            if (expected_dates.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %s", $time, date_str(got));
            end else begin
                want = expected_dates.pop_front();
                if (got.day != want.day || got.mon != want.mon || got.year != want.year ||
                    got.bad != want.bad || got.ovf != want.ovf) begin
                    errors++;
                    $display("%0t: mismatch expected %s, got %s",
                             $time, date_str(want), date_str(got));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", expected_dates.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t row;
        int p, k;
        add_row(REQ_DAYS, 1, 31, 12, 2023, 1'b1, mk_date(1, 1, 2024, 1'b0, 1'b0));
        add_row(REQ_DAYS, 1, 28, 2, 2024, 1'b0, '0);
        add_row(REQ_DAYS, 1, 28, 2, 1900, 1'b0, '0);
        add_row(REQ_DAYS, 1, 29, 2, 2000, 1'b0, '0);
        add_row(REQ_DAYS, 1, 29, 2, 0, 1'b0, '0);
        add_row(REQ_DAYS, 0, 15, 6, 2020, 1'b1, mk_date(15, 6, 2020, 1'b0, 1'b0));
        add_row(REQ_DAYS, 32767, 1, 1, 0, 1'b0, '0);
        add_row(REQ_DAYS, 1, 31, 12, 32767, 1'b1, mk_date(31, 12, 32767, 1'b0, 1'b1));
        add_row(REQ_DAYS, 32767, 1, 1, 32700, 1'b1, mk_date(31, 12, 32767, 1'b0, 1'b1));
        add_row(REQ_DAYS, 365, 1, 3, 32766, 1'b0, '0);
        add_row(REQ_MONTHS, 1, 31, 1, 2023, 1'b0, '0);
        add_row(REQ_MONTHS, 2, 31, 1, 2024, 1'b0, '0);
        add_row(REQ_MONTHS, 1, 15, 12, 32767, 1'b1, mk_date(15, 12, 32767, 1'b0, 1'b1));
        add_row(REQ_MONTHS, 32767, 31, 1, 0, 1'b0, '0);
        add_row(REQ_MONTHS, 32767, 31, 12, 32000, 1'b0, '0);
        add_row(REQ_YEARS, 1, 29, 2, 2024, 1'b1, mk_date(29, 2, 2025, 1'b0, 1'b0));
        add_row(REQ_YEARS, 32767, 1, 1, 0, 1'b1, mk_date(1, 1, 32767, 1'b0, 1'b0));
        add_row(REQ_YEARS, 32767, 5, 5, 1, 1'b1, mk_date(5, 5, 32767, 1'b0, 1'b1));
        add_row(REQ_NONE, 500, 10, 10, 2010, 1'b1, mk_date(10, 10, 2010, 1'b0, 1'b0));
        add_row(REQ_NONE, 3, 30, 2, 2000, 1'b1, mk_date(30, 2, 2000, 1'b1, 1'b0));
        add_row(REQ_DAYS, 5, 1, 0, 2000, 1'b1, mk_date(1, 0, 2000, 1'b1, 1'b0));
        add_row(REQ_MONTHS, 32767, 31, 15, 32767, 1'b1, mk_date(31, 15, 32767, 1'b1, 1'b0));
        add_row(REQ_YEARS, 7, 0, 1, 1999, 1'b1, mk_date(0, 1, 1999, 1'b1, 1'b0));
        add_row(REQ_DAYS, 1, 31, 4, 2021, 1'b1, mk_date(31, 4, 2021, 1'b1, 1'b0));
        add_row(REQ_DAYS, 1, 29, 2, 2023, 1'b1, mk_date(29, 2, 2023, 1'b1, 1'b0));

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            offer(dir_rows[i]);
            n_directed++;
        end

        for (p = 1; p <= 3; p++) begin
            phase = p;
            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                make_random(row);
                offer(row);
                n_random++;
            end
        end
        s_tvalid <= 1'b0;

        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("ran %0d directed and %0d random transactions, %0d results checked",
                 n_directed, n_random, results_seen);
        $display("of these %0d invalid dates and %0d year saturations", n_bad, n_ovf);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/cda_pkg.sv
hw/rtl/cda_useq.sv
hw/rtl/cda_dpath.sv
hw/rtl/calendar_date_advance.sv
hw/rtl/cda_checker.sv
test/tb_calendar_date_advance.sv
